@@ rtl/assert_macros.svh @@
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PFC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pfc check failed");

// checked at every edge, reset included
`define PFC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("pfc check failed");

`endif

@@ rtl/pfc_pkg.sv @@
package pfc_pkg;

    // pixel layout codes
    localparam logic [4:0] FMT_B8G8R8A8 = 5'd0;
    localparam logic [4:0] FMT_B8G8R8X8 = 5'd1;
    localparam logic [4:0] FMT_R8G8B8A8 = 5'd2;
    localparam logic [4:0] FMT_R8G8B8X8 = 5'd3;
    localparam logic [4:0] FMT_B8G8R8   = 5'd4;
    localparam logic [4:0] FMT_R8G8B8   = 5'd5;
    localparam logic [4:0] FMT_B5G5R5A1 = 5'd6;
    localparam logic [4:0] FMT_B5G5R5X1 = 5'd7;
    localparam logic [4:0] FMT_B5G6R5   = 5'd8;
    localparam logic [4:0] FMT_R5G5B5A1 = 5'd9;
    localparam logic [4:0] FMT_R5G5B5X1 = 5'd10;
    localparam logic [4:0] FMT_R5G6B5   = 5'd11;
    localparam logic [4:0] FMT_B4G4R4A4 = 5'd12;
    localparam logic [4:0] FMT_B4G4R4X4 = 5'd13;
    localparam logic [4:0] FMT_R4G4B4A4 = 5'd14;
    localparam logic [4:0] FMT_R4G4B4X4 = 5'd15;
    localparam logic [4:0] FMT_A8       = 5'd16;
    localparam logic [4:0] FMT_R8       = 5'd17;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_FORMAT     = 2'd0;
    localparam logic [1:0] CFG_SOURCE_ALPHA_MODE = 2'd1;
    localparam logic [1:0] CFG_DEST_FORMAT       = 2'd2;
    localparam logic [1:0] CFG_DEST_ALPHA_MODE   = 2'd3;

    localparam int CFG_DATA_W = 5;

    typedef logic [7:0]  t_wide4_lut [16];
    typedef logic [7:0]  t_wide5_lut [32];
    typedef logic [7:0]  t_wide6_lut [64];
    typedef logic [16:0] t_recip_lut [256];

    // shift and subtract quotient, used only to build the tables
    function automatic int unsigned const_quot(input int unsigned n, input int unsigned d);
        int unsigned q;
        int unsigned rem;
        q = 0;
        rem = 0;
        for (int b = 31; b >= 0; b--) begin
            rem = (rem << 1) | ((n >> b) & 32'd1);
            q = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q = q | 32'd1;
            end
        end
        return q;
    endfunction

    function automatic t_wide4_lut mk_wide4();
        t_wide4_lut t;
        for (int i = 0; i < 16; i++) begin
            t[i] = 8'(const_quot(unsigned'(i * 255), 15));
        end
        return t;
    endfunction

    function automatic t_wide5_lut mk_wide5();
        t_wide5_lut t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'(const_quot(unsigned'(i * 255), 31));
        end
        return t;
    endfunction

    function automatic t_wide6_lut mk_wide6();
        t_wide6_lut t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'(const_quot(unsigned'(i * 255), 63));
        end
        return t;
    endfunction

    // floor(2^16 / a), entry zero unused
    function automatic t_recip_lut mk_recip();
        t_recip_lut t;
        t[0] = '0;
        for (int i = 1; i < 256; i++) begin
            t[i] = 17'(const_quot(65536, unsigned'(i)));
        end
        return t;
    endfunction

    localparam t_wide4_lut WIDE4_LUT = mk_wide4();
    localparam t_wide5_lut WIDE5_LUT = mk_wide5();
    localparam t_wide6_lut WIDE6_LUT = mk_wide6();
    localparam t_recip_lut RECIP_LUT = mk_recip();

    // floor(x / 255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

@@ rtl/pixel_format_converter.sv @@
// o_valid rises once an input transfer has passed through stage registers 1 to 7
// throughput: one pixel per cycle when not stalled; each of the 7 stages moves when
// the stage after it is empty or moving, so a stalled output backs up stage by stage
// reset: synchronous, active low; clears the four configuration registers to 0 and
// empties the pipeline
module pixel_format_converter
    import pfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_source_pixel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [31:0]           o_result_pixel
);

    localparam int NSTG = 7;

    logic [4:0] r_src_fmt;
    logic       r_src_pre;
    logic [4:0] r_dst_fmt;
    logic       r_dst_pre;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    // stage 1: unpack and widen
    logic [7:0]  n_s1_ch [3];
    logic [7:0]  n_s1_a;
    logic        n_s1_div;
    logic [7:0]  r_s1_ch [3];
    logic [7:0]  r_s1_a;
    logic        r_s1_div;
    // stage 2: reciprocal product
    logic [15:0] n_s2_num [3];
    logic [15:0] n_s2_q0 [3];
    logic [15:0] r_s2_num [3];
    logic [15:0] r_s2_q0 [3];
    logic [7:0]  r_s2_ch [3];
    logic [7:0]  r_s2_a;
    logic        r_s2_div;
    // stage 3: back product
    logic [15:0] n_s3_qa [3];
    logic [15:0] r_s3_qa [3];
    logic [15:0] r_s3_num [3];
    logic [15:0] r_s3_q0 [3];
    logic [7:0]  r_s3_ch [3];
    logic [7:0]  r_s3_a;
    logic        r_s3_div;
    // stage 4: quotient fix and saturation
    logic [7:0]  n_s4_ch [3];
    logic [7:0]  r_s4_ch [3];
    logic [7:0]  r_s4_a;
    // stage 5: destination alpha product
    logic [15:0] n_s5_p [3];
    logic [15:0] r_s5_p [3];
    logic [7:0]  r_s5_a;
    // stage 6: scale and narrow products
    logic [7:0]  n_s6_ch [3];
    logic [15:0] n_s6_t31 [3];
    logic [15:0] n_s6_t15 [4];
    logic [15:0] n_s6_t63;
    logic [7:0]  r_s6_ch [3];
    logic [15:0] r_s6_t31 [3];
    logic [15:0] r_s6_t15 [4];
    logic [15:0] r_s6_t63;
    logic [7:0]  r_s6_a;
    // stage 7: pack
    logic [31:0] n_s7_pix;
    logic [31:0] r_s7_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= '0;
            r_src_pre <= 1'b0;
            r_dst_fmt <= '0;
            r_dst_pre <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_FORMAT:     r_src_fmt <= i_cfg_data[4:0];
                CFG_SOURCE_ALPHA_MODE: r_src_pre <= i_cfg_data[0];
                CFG_DEST_FORMAT:       r_dst_fmt <= i_cfg_data[4:0];
                CFG_DEST_ALPHA_MODE:   r_dst_pre <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // per-stage advance chain
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_result_pixel = r_s7_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1
    always_comb begin
        logic [31:0] p;
        logic        a8;
        p = i_source_pixel;
        a8 = 1'b0;
        n_s1_ch[0] = '0;
        n_s1_ch[1] = '0;
        n_s1_ch[2] = '0;
        n_s1_a = '0;
        case (r_src_fmt)
            FMT_B8G8R8A8, FMT_B8G8R8X8, FMT_B8G8R8: begin
                n_s1_ch[0] = p[23:16];
                n_s1_ch[1] = p[15:8];
                n_s1_ch[2] = p[7:0];
                n_s1_a = (r_src_fmt == FMT_B8G8R8A8) ? p[31:24] : 8'hFF;
            end
            FMT_R8G8B8A8, FMT_R8G8B8X8, FMT_R8G8B8: begin
                n_s1_ch[0] = p[7:0];
                n_s1_ch[1] = p[15:8];
                n_s1_ch[2] = p[23:16];
                n_s1_a = (r_src_fmt == FMT_R8G8B8A8) ? p[31:24] : 8'hFF;
            end
            FMT_B5G5R5A1, FMT_B5G5R5X1: begin
                n_s1_ch[0] = WIDE5_LUT[p[14:10]];
                n_s1_ch[1] = WIDE5_LUT[p[9:5]];
                n_s1_ch[2] = WIDE5_LUT[p[4:0]];
                n_s1_a = (r_src_fmt == FMT_B5G5R5A1) ? {8{p[15]}} : 8'hFF;
            end
            FMT_B5G6R5: begin
                n_s1_ch[0] = WIDE5_LUT[p[15:11]];
                n_s1_ch[1] = WIDE6_LUT[p[10:5]];
                n_s1_ch[2] = WIDE5_LUT[p[4:0]];
                n_s1_a = 8'hFF;
            end
            FMT_R5G5B5A1, FMT_R5G5B5X1: begin
                n_s1_ch[0] = WIDE5_LUT[p[4:0]];
                n_s1_ch[1] = WIDE5_LUT[p[9:5]];
                n_s1_ch[2] = WIDE5_LUT[p[14:10]];
                n_s1_a = (r_src_fmt == FMT_R5G5B5A1) ? {8{p[15]}} : 8'hFF;
            end
            FMT_R5G6B5: begin
                n_s1_ch[0] = WIDE5_LUT[p[4:0]];
                n_s1_ch[1] = WIDE6_LUT[p[10:5]];
                n_s1_ch[2] = WIDE5_LUT[p[15:11]];
                n_s1_a = 8'hFF;
            end
            FMT_B4G4R4A4, FMT_B4G4R4X4: begin
                n_s1_ch[0] = WIDE4_LUT[p[11:8]];
                n_s1_ch[1] = WIDE4_LUT[p[7:4]];
                n_s1_ch[2] = WIDE4_LUT[p[3:0]];
                n_s1_a = (r_src_fmt == FMT_B4G4R4A4) ? WIDE4_LUT[p[15:12]] : 8'hFF;
            end
            FMT_R4G4B4A4, FMT_R4G4B4X4: begin
                n_s1_ch[0] = WIDE4_LUT[p[3:0]];
                n_s1_ch[1] = WIDE4_LUT[p[7:4]];
                n_s1_ch[2] = WIDE4_LUT[p[11:8]];
                n_s1_a = (r_src_fmt == FMT_R4G4B4A4) ? WIDE4_LUT[p[15:12]] : 8'hFF;
            end
            FMT_A8: begin
                n_s1_ch[0] = 8'hFF;
                n_s1_ch[1] = 8'hFF;
                n_s1_ch[2] = 8'hFF;
                n_s1_a = p[7:0];
                a8 = 1'b1;
            end
            FMT_R8: begin
                n_s1_ch[0] = p[7:0];
                n_s1_ch[1] = p[7:0];
                n_s1_ch[2] = p[7:0];
                n_s1_a = 8'hFF;
            end
            default: begin
            end
        endcase
        n_s1_div = r_src_pre && (n_s1_a != 8'd0) && !a8;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_ch <= n_s1_ch;
            r_s1_a <= n_s1_a;
            r_s1_div <= n_s1_div;
        end
    end

    // stage 2: q0 = c*255 * floor(2^16/a) >> 16, low by at most one
    always_comb begin
        logic [16:0] m;
        logic [32:0] prod;
        m = RECIP_LUT[r_s1_a];
        for (int c = 0; c < 3; c++) begin
            n_s2_num[c] = {r_s1_ch[c], 8'd0} - 16'(r_s1_ch[c]);
            prod = 33'(n_s2_num[c]) * 33'(m);
            n_s2_q0[c] = prod[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s2_num <= n_s2_num;
            r_s2_q0 <= n_s2_q0;
            r_s2_ch <= r_s1_ch;
            r_s2_a <= r_s1_a;
            r_s2_div <= r_s1_div;
        end
    end

    // stage 3
    always_comb begin
        logic [23:0] prod;
        for (int c = 0; c < 3; c++) begin
            prod = 24'(r_s2_q0[c]) * 24'(r_s2_a);
            n_s3_qa[c] = prod[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s3_qa <= n_s3_qa;
            r_s3_num <= r_s2_num;
            r_s3_q0 <= r_s2_q0;
            r_s3_ch <= r_s2_ch;
            r_s3_a <= r_s2_a;
            r_s3_div <= r_s2_div;
        end
    end

    // stage 4
    always_comb begin
        logic [15:0] rem;
        logic [16:0] q;
        for (int c = 0; c < 3; c++) begin
            rem = r_s3_num[c] - r_s3_qa[c];
            q = 17'(r_s3_q0[c]) + ((rem >= 16'(r_s3_a)) ? 17'd1 : 17'd0);
            if (!r_s3_div) begin
                n_s4_ch[c] = r_s3_ch[c];
            end else if (q > 17'd255) begin
                n_s4_ch[c] = 8'hFF;
            end else begin
                n_s4_ch[c] = q[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s4_ch <= n_s4_ch;
            r_s4_a <= r_s3_a;
        end
    end

    // stage 5: c*a, or c*255 so that the divide gives c back
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_dst_pre) begin
                n_s5_p[c] = 16'(r_s4_ch[c]) * 16'(r_s4_a);
            end else begin
                n_s5_p[c] = {r_s4_ch[c], 8'd0} - 16'(r_s4_ch[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s5_p <= n_s5_p;
            r_s5_a <= r_s4_a;
        end
    end

    // stage 6
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s6_ch[c] = div255(r_s5_p[c]);
            n_s6_t31[c] = 16'(n_s6_ch[c]) * 16'd31;
            n_s6_t15[c] = 16'(n_s6_ch[c]) * 16'd15;
        end
        n_s6_t15[3] = 16'(r_s5_a) * 16'd15;
        n_s6_t63 = 16'(n_s6_ch[1]) * 16'd63;
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s6_ch <= n_s6_ch;
            r_s6_t31 <= n_s6_t31;
            r_s6_t15 <= n_s6_t15;
            r_s6_t63 <= n_s6_t63;
            r_s6_a <= r_s5_a;
        end
    end

    // stage 7
    always_comb begin
        logic [7:0] q31 [3];
        logic [7:0] q15 [4];
        logic [7:0] q63;
        logic [4:0] r5, g5, b5;
        logic [5:0] g6;
        logic [3:0] r4, g4, b4, a4;
        logic       a1;
        for (int c = 0; c < 3; c++) begin
            q31[c] = div255(r_s6_t31[c]);
        end
        for (int c = 0; c < 4; c++) begin
            q15[c] = div255(r_s6_t15[c]);
        end
        q63 = div255(r_s6_t63);
        r5 = q31[0][4:0];
        g5 = q31[1][4:0];
        b5 = q31[2][4:0];
        g6 = q63[5:0];
        r4 = q15[0][3:0];
        g4 = q15[1][3:0];
        b4 = q15[2][3:0];
        a4 = q15[3][3:0];
        a1 = (r_s6_a == 8'hFF);
        case (r_dst_fmt)
            FMT_B8G8R8A8: n_s7_pix = {r_s6_a, r_s6_ch[0], r_s6_ch[1], r_s6_ch[2]};
            FMT_R8G8B8A8: n_s7_pix = {r_s6_a, r_s6_ch[2], r_s6_ch[1], r_s6_ch[0]};
            FMT_B8G8R8X8, FMT_B8G8R8:
                n_s7_pix = {8'd0, r_s6_ch[0], r_s6_ch[1], r_s6_ch[2]};
            FMT_R8G8B8X8, FMT_R8G8B8:
                n_s7_pix = {8'd0, r_s6_ch[2], r_s6_ch[1], r_s6_ch[0]};
            FMT_B5G5R5A1: n_s7_pix = {16'd0, a1, r5, g5, b5};
            FMT_B5G5R5X1: n_s7_pix = {16'd0, 1'b0, r5, g5, b5};
            FMT_B5G6R5:   n_s7_pix = {16'd0, r5, g6, b5};
            FMT_R5G5B5A1: n_s7_pix = {16'd0, a1, b5, g5, r5};
            FMT_R5G5B5X1: n_s7_pix = {16'd0, 1'b0, b5, g5, r5};
            FMT_R5G6B5:   n_s7_pix = {16'd0, b5, g6, r5};
            FMT_B4G4R4A4: n_s7_pix = {16'd0, a4, r4, g4, b4};
            FMT_B4G4R4X4: n_s7_pix = {16'd0, 4'd0, r4, g4, b4};
            FMT_R4G4B4A4: n_s7_pix = {16'd0, a4, b4, g4, r4};
            FMT_R4G4B4X4: n_s7_pix = {16'd0, 4'd0, b4, g4, r4};
            FMT_A8:       n_s7_pix = {24'd0, r_s6_a};
            FMT_R8:       n_s7_pix = {24'd0, r_s6_ch[0]};
            default:      n_s7_pix = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s7_pix <= n_s7_pix;
        end
    end

endmodule

@@ rtl/pfc_checker.sv @@
`include "assert_macros.svh"

module pfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_result_pixel
);

    // output held while stalled
    `PFC_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_result_pixel))
    // input backs up only when the output is full and stalled
    `PFC_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall)
    // reset empties the pipeline
    `PFC_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid)
    `PFC_ASSERT_ALWAYS(a_rst_ready, !i_rst_n |=> !o_stall)

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_pixel (o_result_pixel)
);

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam logic [4:0] FMT_UNDEFINED = 5'd31;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1825;
    localparam int NUM_VECS = 25;

    typedef struct packed {
        logic [4:0]  src_fmt;
        logic        src_premul;
        logic [4:0]  dst_fmt;
        logic        dst_premul;
        logic [31:0] pixel;
        logic        has_result;
        logic [31:0] result;
    } t_vec;

    // has_result low: the expected pixel comes from convert_pixel
    localparam t_vec DIRECTED_VECS [NUM_VECS] = '{
        '{FMT_B8G8R8A8, 1'b0, FMT_B8G8R8A8, 1'b0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{FMT_B8G8R8A8, 1'b0, FMT_B8G8R8A8, 1'b0, 32'h00000000, 1'b1, 32'h00000000},
        '{FMT_B8G8R8A8, 1'b0, FMT_B8G8R8A8, 1'b0, 32'h80402010, 1'b1, 32'h80402010},
        '{FMT_R8G8B8A8, 1'b0, FMT_B8G8R8A8, 1'b0, 32'h11223344, 1'b1, 32'h11443322},
        '{FMT_B8G8R8A8, 1'b0, FMT_B8G8R8X8, 1'b0, 32'hAB123456, 1'b1, 32'h00123456},
        '{FMT_B8G8R8A8, 1'b0, FMT_R8G8B8,   1'b0, 32'hAB123456, 1'b1, 32'h00563412},
        '{FMT_A8,       1'b0, FMT_B8G8R8A8, 1'b0, 32'hFFFFFF5A, 1'b1, 32'h5AFFFFFF},
        '{FMT_A8,       1'b1, FMT_B8G8R8A8, 1'b0, 32'h0000005A, 1'b1, 32'h5AFFFFFF},
        '{FMT_R8,       1'b0, FMT_B8G8R8A8, 1'b0, 32'hFFFFFFC3, 1'b1, 32'hFFC3C3C3},
        '{FMT_UNDEFINED, 1'b0, FMT_B8G8R8A8, 1'b0, 32'hDEADBEEF, 1'b1, 32'h00000000},
        '{FMT_B8G8R8A8, 1'b0, FMT_UNDEFINED, 1'b0, 32'h12345678, 1'b1, 32'h00000000},
        '{FMT_B8G8R8A8, 1'b0, FMT_A8,       1'b0, 32'hAB123456, 1'b1, 32'h000000AB},
        '{FMT_B8G8R8A8, 1'b0, FMT_R8,       1'b0, 32'hAB123456, 1'b1, 32'h00000012},
        '{FMT_B5G5R5A1, 1'b0, FMT_B8G8R8A8, 1'b0, 32'h0000FFFF, 1'b1, 32'hFFFFFFFF},
        '{FMT_B5G5R5A1, 1'b0, FMT_B8G8R8A8, 1'b0, 32'hFFFF7FFF, 1'b1, 32'h00FFFFFF},
        '{FMT_B8G8R8A8, 1'b0, FMT_B5G5R5A1, 1'b0, 32'hFFFFFFFF, 1'b1, 32'h0000FFFF},
        '{FMT_B8G8R8A8, 1'b0, FMT_B5G5R5A1, 1'b0, 32'hFEFFFFFF, 1'b1, 32'h00007FFF},
        '{FMT_B8G8R8A8, 1'b1, FMT_B8G8R8A8, 1'b0, 32'h00808080, 1'b1, 32'h00808080},
        '{FMT_B8G8R8A8, 1'b1, FMT_B8G8R8A8, 1'b0, 32'h40800000, 1'b1, 32'h40FF0000},
        '{FMT_B8G8R8A8, 1'b0, FMT_B8G8R8A8, 1'b1, 32'h00FFFFFF, 1'b1, 32'h00000000},
        '{FMT_B8G8R8A8, 1'b0, FMT_B8G8R8A8, 1'b1, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{FMT_B5G6R5,   1'b0, FMT_R5G6B5,   1'b0, 32'h0000ABCD, 1'b0, 32'h00000000},
        '{FMT_B4G4R4A4, 1'b1, FMT_R4G4B4A4, 1'b1, 32'h0000C5A7, 1'b0, 32'h00000000},
        '{FMT_R5G5B5A1, 1'b1, FMT_B5G5R5X1, 1'b1, 32'h0000B3D1, 1'b0, 32'h00000000},
        '{FMT_R4G4B4X4, 1'b0, FMT_R5G5B5X1, 1'b1, 32'h12345678, 1'b0, 32'h00000000}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [31:0]           i_source_pixel = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [31:0]           o_result_pixel;

    logic [4:0]  cfg_src_fmt = FMT_B8G8R8A8;
    logic        cfg_src_premul = 1'b0;
    logic [4:0]  cfg_dst_fmt = FMT_B8G8R8A8;
    logic        cfg_dst_premul = 1'b0;

    logic [31:0] pending_pixels [$];
    logic [31:0] expected_pixel;
    int          failures = 0;
    logic        calm = 1'b0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          run_left = 0;

    pixel_format_converter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_source_pixel (i_source_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_pixel (o_result_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned expand(input int unsigned v, input int unsigned top);
        return v * 255 / top;
    endfunction

    function automatic int unsigned shrink(input int unsigned v, input int unsigned top);
        return v * top / 255;
    endfunction

    function automatic int unsigned unpremultiply(input int unsigned c, input int unsigned a);
        int unsigned q;
        q = c * 255 / a;
        return (q > 255) ? 255 : q;
    endfunction

    function automatic logic [31:0] convert_pixel(input logic [31:0] p);
        int unsigned r, g, b, a;
        logic        white;
        r = 0;
        g = 0;
        b = 0;
        a = 0;
        white = 1'b0;
        case (cfg_src_fmt)
            FMT_B8G8R8A8, FMT_B8G8R8X8, FMT_B8G8R8: begin
                r = p[23:16];
                g = p[15:8];
                b = p[7:0];
                a = (cfg_src_fmt == FMT_B8G8R8A8) ? p[31:24] : 255;
            end
            FMT_R8G8B8A8, FMT_R8G8B8X8, FMT_R8G8B8: begin
                r = p[7:0];
                g = p[15:8];
                b = p[23:16];
                a = (cfg_src_fmt == FMT_R8G8B8A8) ? p[31:24] : 255;
            end
            FMT_B5G5R5A1, FMT_B5G5R5X1: begin
                r = expand(p[14:10], 31);
                g = expand(p[9:5], 31);
                b = expand(p[4:0], 31);
                a = (cfg_src_fmt == FMT_B5G5R5A1 && !p[15]) ? 0 : 255;
            end
            FMT_B5G6R5: begin
                r = expand(p[15:11], 31);
                g = expand(p[10:5], 63);
                b = expand(p[4:0], 31);
                a = 255;
            end
            FMT_R5G5B5A1, FMT_R5G5B5X1: begin
                r = expand(p[4:0], 31);
                g = expand(p[9:5], 31);
                b = expand(p[14:10], 31);
                a = (cfg_src_fmt == FMT_R5G5B5A1 && !p[15]) ? 0 : 255;
            end
            FMT_R5G6B5: begin
                r = expand(p[4:0], 31);
                g = expand(p[10:5], 63);
                b = expand(p[15:11], 31);
                a = 255;
            end
            FMT_B4G4R4A4, FMT_B4G4R4X4: begin
                r = expand(p[11:8], 15);
                g = expand(p[7:4], 15);
                b = expand(p[3:0], 15);
                a = (cfg_src_fmt == FMT_B4G4R4A4) ? expand(p[15:12], 15) : 255;
            end
            FMT_R4G4B4A4, FMT_R4G4B4X4: begin
                r = expand(p[3:0], 15);
                g = expand(p[7:4], 15);
                b = expand(p[11:8], 15);
                a = (cfg_src_fmt == FMT_R4G4B4A4) ? expand(p[15:12], 15) : 255;
            end
            FMT_A8: begin
                r = 255;
                g = 255;
                b = 255;
                a = p[7:0];
                white = 1'b1;
            end
            FMT_R8: begin
                r = p[7:0];
                g = r;
                b = r;
                a = 255;
            end
            default: ;
        endcase
        if (cfg_src_premul && !white && a != 0) begin
            r = unpremultiply(r, a);
            g = unpremultiply(g, a);
            b = unpremultiply(b, a);
        end
        if (cfg_dst_premul) begin
            r = r * a / 255;
            g = g * a / 255;
            b = b * a / 255;
        end
        case (cfg_dst_fmt)
            FMT_B8G8R8A8: return 32'(b | (g << 8) | (r << 16) | (a << 24));
            FMT_R8G8B8A8: return 32'(r | (g << 8) | (b << 16) | (a << 24));
            FMT_B8G8R8X8, FMT_B8G8R8: return 32'(b | (g << 8) | (r << 16));
            FMT_R8G8B8X8, FMT_R8G8B8: return 32'(r | (g << 8) | (b << 16));
            FMT_B5G5R5A1: return 32'(shrink(b, 31) | (shrink(g, 31) << 5)
                | (shrink(r, 31) << 10) | ((a / 255) << 15));
            FMT_B5G5R5X1: return 32'(shrink(b, 31) | (shrink(g, 31) << 5)
                | (shrink(r, 31) << 10));
            FMT_B5G6R5: return 32'(shrink(b, 31) | (shrink(g, 63) << 5)
                | (shrink(r, 31) << 11));
            FMT_R5G5B5A1: return 32'(shrink(r, 31) | (shrink(g, 31) << 5)
                | (shrink(b, 31) << 10) | ((a / 255) << 15));
            FMT_R5G5B5X1: return 32'(shrink(r, 31) | (shrink(g, 31) << 5)
                | (shrink(b, 31) << 10));
            FMT_R5G6B5: return 32'(shrink(r, 31) | (shrink(g, 63) << 5)
                | (shrink(b, 31) << 11));
            FMT_B4G4R4A4: return 32'(shrink(b, 15) | (shrink(g, 15) << 4)
                | (shrink(r, 15) << 8) | (shrink(a, 15) << 12));
            FMT_B4G4R4X4: return 32'(shrink(b, 15) | (shrink(g, 15) << 4)
                | (shrink(r, 15) << 8));
            FMT_R4G4B4A4: return 32'(shrink(r, 15) | (shrink(g, 15) << 4)
                | (shrink(b, 15) << 8) | (shrink(a, 15) << 12));
            FMT_R4G4B4X4: return 32'(shrink(r, 15) | (shrink(g, 15) << 4)
                | (shrink(b, 15) << 8));
            FMT_A8: return 32'(a);
            FMT_R8: return 32'(r);
            default: return 32'h0;
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic logic [4:0] pick_format();
        if ($urandom_range(0, 9) == 0) begin
            return 5'($urandom_range(18, 31));
        end
        return 5'($urandom_range(0, 17));
    endfunction

    function automatic logic [31:0] random_pixel();
        logic [31:0] p;
        int unsigned a;
        p = $urandom;
        case ($urandom_range(0, 9))
            0: p[31:24] = 8'h00;
            1: p[31:24] = 8'hFF;
            2: p[15:12] = 4'h0;
            3: p[15:12] = 4'hF;
            4, 5: begin
                // well-formed premultiplied 8-bit pixel
                a = $urandom_range(1, 255);
                p[31:24] = 8'(a);
                p[23:16] = 8'($urandom_range(0, a));
                p[15:8] = 8'($urandom_range(0, a));
                p[7:0] = 8'($urandom_range(0, a));
            end
            6: begin
                a = $urandom_range(0, 15);
                p[15:12] = 4'(a);
                p[11:8] = 4'($urandom_range(0, a));
                p[7:4] = 4'($urandom_range(0, a));
                p[3:0] = 4'($urandom_range(0, a));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input logic [31:0] p, input logic [31:0] want);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_source_pixel <= p;
        do @(posedge i_clk); while (o_stall);
        pending_pixels.push_back(want);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [4:0] src_fmt, input logic src_premul,
                                input logic [4:0] dst_fmt, input logic dst_premul);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SOURCE_FORMAT;
        i_cfg_data <= CFG_DATA_W'(src_fmt);
        @(posedge i_clk);
        i_cfg_index <= CFG_SOURCE_ALPHA_MODE;
        i_cfg_data <= CFG_DATA_W'(src_premul);
        @(posedge i_clk);
        i_cfg_index <= CFG_DEST_FORMAT;
        i_cfg_data <= CFG_DATA_W'(dst_fmt);
        @(posedge i_clk);
        i_cfg_index <= CFG_DEST_ALPHA_MODE;
        i_cfg_data <= CFG_DATA_W'(dst_premul);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_src_fmt = src_fmt;
        cfg_src_premul = src_premul;
        cfg_dst_fmt = dst_fmt;
        cfg_dst_premul = dst_premul;
    endtask

    // output side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left = run_left - 1;
            i_stall <= 1'b0;
        end else begin
            stall_left = idle_len();
            run_left = $urandom_range(1, 12);
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                failures++;
                if (failures < 100) begin
                    $display("%0t: unexpected transfer, result_pixel %h", $time,
                             o_result_pixel);
                end
            end else begin
                expected_pixel = pending_pixels.pop_front();
                if (o_result_pixel !== expected_pixel) begin
                    failures++;
                    if (failures < 100) begin
                        $display("%0t: result_pixel expected %h, got %h", $time,
                                 expected_pixel, o_result_pixel);
                    end
                end
            end
        end
    end

    initial begin
        t_vec        v;
        logic [31:0] pix;
        logic [4:0]  src_fmt, dst_fmt;
        logic        src_premul, dst_premul;
        int          sent, phase, phase_len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < NUM_VECS; k++) begin
            v = DIRECTED_VECS[k];
            if (v.src_fmt != cfg_src_fmt || v.src_premul != cfg_src_premul
                || v.dst_fmt != cfg_dst_fmt || v.dst_premul != cfg_dst_premul) begin
                wait_idle();
                apply_config(v.src_fmt, v.src_premul, v.dst_fmt, v.dst_premul);
            end
            send_pixel(v.pixel, v.has_result ? v.result : convert_pixel(v.pixel));
        end
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            src_fmt = pick_format();
            dst_fmt = pick_format();
            src_premul = 1'($urandom_range(0, 1));
            dst_premul = 1'($urandom_range(0, 1));
            calm = 1'b0;
            wait_idle();
            apply_config(src_fmt, src_premul, dst_fmt, dst_premul);
            calm = (phase % 6 == 4);
            phase_len = $urandom_range(20, 70);
            if (phase == 3 || phase == 21) begin
                // long hold-off on the output while pixels keep coming
                hold_requests++;
                phase_len = 80;
            end
            for (int n = 0; n < phase_len; n++) begin
                if (phase == 8 && n == phase_len / 2) begin
                    i_valid <= 1'b0;
                    do @(posedge i_clk); while (pending_pixels.size() != 0);
                end
                pix = random_pixel();
                send_pixel(pix, convert_pixel(pix));
            end
            sent += phase_len;
            phase++;
        end
        calm = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
